FILE: design/rdpc_pkg.sv
package rdpc_pkg;

    localparam int POS_W    = 20;
    localparam int VEL_W    = 19;
    localparam int RAD_W    = 6;
    localparam int RS_W     = RAD_W + 1;
    localparam int MASS_W   = 2 * RAD_W;
    localparam int MSUM_W   = MASS_W + 1;
    localparam int DIST_W   = 15;
    localparam int SQRT_W   = 2 * DIST_W;
    localparam int NUM_W    = 31;
    localparam int NRM_W    = 17;
    localparam int PDIV_W   = 21;
    localparam int VDIV_W   = 33;
    localparam int GMAG_W   = 21;
    localparam int ONE_Q16  = 65536;
    localparam int POS_MAX  = 524287;
    localparam int POS_MIN  = -524288;
    localparam int VEL_MAX  = 262143;
    localparam int VEL_MIN  = -262144;
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 160;
    localparam int OUT_TUSER_W = 2;

    typedef struct packed {
        logic signed [POS_W-1:0] x1;
        logic signed [POS_W-1:0] y1;
        logic signed [VEL_W-1:0] vx1;
        logic signed [VEL_W-1:0] vy1;
        logic        [RAD_W-1:0] r1;
        logic signed [POS_W-1:0] x2;
        logic signed [POS_W-1:0] y2;
        logic signed [VEL_W-1:0] vx2;
        logic signed [VEL_W-1:0] vy2;
        logic        [RAD_W-1:0] r2;
    } t_pair;

    typedef struct packed {
        t_pair                   pair;
        logic                    sx;
        logic                    sy;
        logic [DIST_W-1:0]       mx;
        logic [DIST_W-1:0]       my;
        logic signed [VEL_W:0]   dvx;
        logic signed [VEL_W:0]   dvy;
        logic [RS_W-1:0]         rs;
        logic                    ov;
    } t_ctxa;

    typedef struct packed {
        t_ctxa             ca;
        logic [DIST_W-1:0] ovl;
        logic              zero;
    } t_ctxb;

    typedef struct packed {
        t_pair                 pair;
        logic                  ov;
        logic [RS_W-1:0]       rs;
        logic signed [VEL_W:0] dvx;
        logic signed [VEL_W:0] dvy;
        logic [NRM_W-1:0]      nxm;
        logic [NRM_W-1:0]      nym;
        logic                  nxs;
        logic                  nys;
        logic [DIST_W-1:0]     ovl;
    } t_ctxc;

    typedef struct packed {
        t_ctxc c;
        logic  imp;
        logic  vneg;
    } t_ctxd;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+2:0] v);
        logic signed [POS_W-1:0] res;
        if (v > (POS_W+3)'(POS_MAX)) begin
            res = POS_W'(POS_MAX);
        end else if (v < (POS_W+3)'(POS_MIN)) begin
            res = POS_W'(POS_MIN);
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VEL_W+4:0] v);
        logic signed [VEL_W-1:0] res;
        if (v > (VEL_W+5)'(VEL_MAX)) begin
            res = VEL_W'(VEL_MAX);
        end else if (v < (VEL_W+5)'(VEL_MIN)) begin
            res = VEL_W'(VEL_MIN);
        end else begin
            res = v[VEL_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: design/rdpc_delay.sv
module rdpc_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_pipe[k] <= r_pipe[k-1];
            end
        end
    end

    assign o_data = r_pipe[DEPTH-1];

endmodule

FILE: design/rdpc_sqrt.sv
module rdpc_sqrt #(
    parameter int IN_W = 30
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [IN_W-1:0]   i_rad,
    output logic [IN_W/2-1:0] o_root
);

    localparam int ROOT_W = IN_W / 2;
    localparam int REM_W  = ROOT_W + 3;

    logic [IN_W-1:0]   r_rad  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar gi = 0; gi < ROOT_W; gi++) begin : g_stage
        logic [IN_W-1:0]   rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;

        if (gi == 0) begin : g_first
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = r_rad[gi-1];
            assign rem_in  = r_rem[gi-1];
            assign root_in = r_root[gi-1];
        end

        assign rem_sh = {rem_in[REM_W-3:0], rad_in[IN_W-1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[gi] <= {rad_in[IN_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem[gi]  <= rem_sh - trial;
                    r_root[gi] <= {root_in[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[gi]  <= rem_sh;
                    r_root[gi] <= {root_in[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

FILE: design/rdpc_div.sv
module rdpc_div #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 15
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [NUM_W-1:0] r_num [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];

    for (genvar gi = 0; gi < NUM_W; gi++) begin : g_stage
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] quo_in;
        logic [DEN_W:0]   rem_sh;
        logic [DEN_W:0]   diff;
        logic             fits;

        if (gi == 0) begin : g_first
            assign num_in = i_num;
            assign den_in = i_den;
            assign rem_in = '0;
            assign quo_in = '0;
        end else begin : g_next
            assign num_in = r_num[gi-1];
            assign den_in = r_den[gi-1];
            assign rem_in = r_rem[gi-1];
            assign quo_in = r_quo[gi-1];
        end

        assign rem_sh = {rem_in, num_in[NUM_W-1]};
        assign fits   = rem_sh >= {1'b0, den_in};
        assign diff   = rem_sh - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[gi] <= {num_in[NUM_W-2:0], 1'b0};
                r_den[gi] <= den_in;
                r_rem[gi] <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                r_quo[gi] <= {quo_in[NUM_W-2:0], fits};
            end
        end
    end

    assign o_quo = r_quo[NUM_W-1];

endmodule

FILE: design/resolve_disk_pair_collision.sv
// Throughput: one item per cycle; the whole pipeline advances while the output
// register is empty or being taken, and holds otherwise.
// The depth is set by the bit-serial square root and the unit-normal and impulse divider chains.
// Reset clears only the valid bits of the pipeline.
module resolve_disk_pair_collision (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // first_x, first_y, first_radius, first_vx, first_vy,
    // second_x, second_y, second_radius, second_vx, second_vy
    input  logic [rdpc_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // new_first_x, new_first_y, new_first_vx, new_first_vy,
    // new_second_x, new_second_y, new_second_vx, new_second_vy, zero fill
    output logic [rdpc_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // overlapped, impulse_applied
    output logic [rdpc_pkg::OUT_TUSER_W-1:0]   o_m_tuser
);

    import rdpc_pkg::*;

    localparam int LAT    = 3 + DIST_W + 1 + NUM_W + 4 + VDIV_W + 2;
    localparam int PALIGN = VDIV_W + 1 - PDIV_W;

    logic           en;
    logic [LAT-1:0] r_vld;

    assign en         = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // Stage 1: differences.
    t_pair n_pair;
    assign n_pair.x1  = i_s_tdata[19:0];
    assign n_pair.y1  = i_s_tdata[39:20];
    assign n_pair.r1  = i_s_tdata[45:40];
    assign n_pair.vx1 = i_s_tdata[64:46];
    assign n_pair.vy1 = i_s_tdata[83:65];
    assign n_pair.x2  = i_s_tdata[103:84];
    assign n_pair.y2  = i_s_tdata[123:104];
    assign n_pair.r2  = i_s_tdata[129:124];
    assign n_pair.vx2 = i_s_tdata[148:130];
    assign n_pair.vy2 = i_s_tdata[167:149];

    t_pair                 r1_pair;
    logic signed [POS_W:0] r1_dx, r1_dy;
    logic signed [VEL_W:0] r1_dvx, r1_dvy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pair <= n_pair;
            r1_dx   <= (POS_W+1)'(n_pair.x1) - (POS_W+1)'(n_pair.x2);
            r1_dy   <= (POS_W+1)'(n_pair.y1) - (POS_W+1)'(n_pair.y2);
            r1_dvx  <= (VEL_W+1)'(n_pair.vx1) - (VEL_W+1)'(n_pair.vx2);
            r1_dvy  <= (VEL_W+1)'(n_pair.vy1) - (VEL_W+1)'(n_pair.vy2);
        end
    end

    // Stage 2: squares.
    logic [POS_W:0]     n_adx, n_ady;
    logic [RS_W-1:0]    n_rs;
    t_ctxa              r2_ca;
    logic [2*POS_W+1:0] r2_sqx, r2_sqy;
    logic [2*RS_W-1:0]  r2_rs2;

    assign n_adx = r1_dx[POS_W] ? (POS_W+1)'(-r1_dx) : (POS_W+1)'(r1_dx);
    assign n_ady = r1_dy[POS_W] ? (POS_W+1)'(-r1_dy) : (POS_W+1)'(r1_dy);
    assign n_rs  = {1'b0, r1_pair.r1} + {1'b0, r1_pair.r2};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ca.pair <= r1_pair;
            r2_ca.sx   <= r1_dx[POS_W];
            r2_ca.sy   <= r1_dy[POS_W];
            r2_ca.mx   <= n_adx[DIST_W-1:0];
            r2_ca.my   <= n_ady[DIST_W-1:0];
            r2_ca.dvx  <= r1_dvx;
            r2_ca.dvy  <= r1_dvy;
            r2_ca.rs   <= n_rs;
            r2_ca.ov   <= 1'b0;
            r2_sqx     <= (2*POS_W+2)'(n_adx * n_adx);
            r2_sqy     <= (2*POS_W+2)'(n_ady * n_ady);
            r2_rs2     <= (2*RS_W)'(n_rs * n_rs);
        end
    end

    // Stage 3: overlap test.
    logic [2*POS_W+2:0] n_d2;
    t_ctxa              n_ca3;
    t_ctxa              r3_ca;
    logic [SQRT_W-1:0]  r3_rad;

    assign n_d2 = {1'b0, r2_sqx} + {1'b0, r2_sqy};

    always_comb begin
        n_ca3    = r2_ca;
        n_ca3.ov = n_d2 < (2*POS_W+3)'({r2_rs2, 16'b0});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ca  <= n_ca3;
            r3_rad <= n_d2[SQRT_W-1:0];
        end
    end

    // Distance.
    logic [DIST_W-1:0]   sq_dist;
    logic [$bits(t_ctxa)-1:0] ca_d_bits;
    t_ctxa               ca_d;

    rdpc_sqrt #(.IN_W(SQRT_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r3_rad),
        .o_root (sq_dist)
    );

    rdpc_delay #(.W($bits(t_ctxa)), .DEPTH(DIST_W)) u_dly_a (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data (r3_ca),
        .o_data (ca_d_bits)
    );
    assign ca_d = t_ctxa'(ca_d_bits);

    // Stage after the root: divider operands and overlap depth.
    t_ctxb            r19_cb;
    logic [NUM_W-1:0] r19_numx, r19_numy;
    logic [DIST_W-1:0] r19_dist;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r19_cb.ca   <= ca_d;
            r19_cb.ovl  <= {ca_d.rs, 8'b0} - sq_dist;
            r19_cb.zero <= sq_dist == '0;
            r19_numx    <= NUM_W'({ca_d.mx, 16'b0});
            r19_numy    <= NUM_W'({ca_d.my, 16'b0});
            r19_dist    <= sq_dist;
        end
    end

    // Unit normal.
    logic [NUM_W-1:0] qnx, qny;
    logic [$bits(t_ctxb)-1:0] cb_d_bits;
    t_ctxb            cb_d;

    rdpc_div #(.NUM_W(NUM_W), .DEN_W(DIST_W)) u_div_nx (
        .i_clk (i_clk), .i_en (en), .i_num (r19_numx), .i_den (r19_dist), .o_quo (qnx)
    );
    rdpc_div #(.NUM_W(NUM_W), .DEN_W(DIST_W)) u_div_ny (
        .i_clk (i_clk), .i_en (en), .i_num (r19_numy), .i_den (r19_dist), .o_quo (qny)
    );
    rdpc_delay #(.W($bits(t_ctxb)), .DEPTH(NUM_W)) u_dly_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data (r19_cb),
        .o_data (cb_d_bits)
    );
    assign cb_d = t_ctxb'(cb_d_bits);

    t_ctxc r51_cc;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r51_cc.pair <= cb_d.ca.pair;
            r51_cc.ov   <= cb_d.ca.ov;
            r51_cc.rs   <= cb_d.ca.rs;
            r51_cc.dvx  <= cb_d.ca.dvx;
            r51_cc.dvy  <= cb_d.ca.dvy;
            r51_cc.ovl  <= cb_d.ovl;
            r51_cc.nxm  <= cb_d.zero ? NRM_W'(ONE_Q16) : qnx[NRM_W-1:0];
            r51_cc.nym  <= cb_d.zero ? '0 : qny[NRM_W-1:0];
            r51_cc.nxs  <= cb_d.zero ? 1'b0 : cb_d.ca.sx;
            r51_cc.nys  <= cb_d.zero ? 1'b0 : cb_d.ca.sy;
        end
    end

    // Stage 52: first products.
    logic signed [NRM_W:0]       n_nx, n_ny;
    t_ctxc                       r52_cc;
    logic [NRM_W+DIST_W-1:0]     r52_pxo, r52_pyo;
    logic signed [VEL_W+NRM_W+1:0] r52_ex, r52_ey;
    logic [MASS_W-1:0]           r52_m1, r52_m2;

    assign n_nx = r51_cc.nxs ? -$signed({1'b0, r51_cc.nxm}) : $signed({1'b0, r51_cc.nxm});
    assign n_ny = r51_cc.nys ? -$signed({1'b0, r51_cc.nym}) : $signed({1'b0, r51_cc.nym});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r52_cc  <= r51_cc;
            r52_pxo <= (NRM_W+DIST_W)'(r51_cc.nxm * r51_cc.ovl);
            r52_pyo <= (NRM_W+DIST_W)'(r51_cc.nym * r51_cc.ovl);
            r52_ex  <= r51_cc.dvx * n_nx;
            r52_ey  <= r51_cc.dvy * n_ny;
            r52_m1  <= MASS_W'(r51_cc.pair.r1 * r51_cc.pair.r1);
            r52_m2  <= MASS_W'(r51_cc.pair.r2 * r51_cc.pair.r2);
        end
    end

    // Stage 53: weighted shifts and normal velocity.
    localparam int PP_W = NRM_W + DIST_W + RAD_W;

    logic [PP_W-1:0]               n_px1, n_py1, n_px2, n_py2;
    t_ctxc                         r53_cc;
    logic [PDIV_W-1:0]             r53_ax1, r53_ay1, r53_ax2, r53_ay2;
    logic signed [VEL_W+NRM_W+2:0] r53_van;
    logic [MASS_W-1:0]             r53_m1, r53_m2;
    logic [MSUM_W-1:0]             r53_msum;

    assign n_px1 = PP_W'(r52_pxo * r52_cc.pair.r2);
    assign n_py1 = PP_W'(r52_pyo * r52_cc.pair.r2);
    assign n_px2 = PP_W'(r52_pxo * r52_cc.pair.r1);
    assign n_py2 = PP_W'(r52_pyo * r52_cc.pair.r1);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r53_cc   <= r52_cc;
            r53_ax1  <= n_px1[16 +: PDIV_W];
            r53_ay1  <= n_py1[16 +: PDIV_W];
            r53_ax2  <= n_px2[16 +: PDIV_W];
            r53_ay2  <= n_py2[16 +: PDIV_W];
            r53_van  <= (VEL_W+NRM_W+3)'(r52_ex) + (VEL_W+NRM_W+3)'(r52_ey);
            r53_m1   <= r52_m1;
            r53_m2   <= r52_m2;
            r53_msum <= MSUM_W'(r52_m1) + MSUM_W'(r52_m2);
        end
    end

    // Stage 54: impulse numerators.
    localparam int VAN_W = VEL_W + NRM_W + 2;
    localparam int VP_W  = VAN_W + MASS_W;

    logic [VAN_W-1:0]  n_avan;
    logic [VP_W-1:0]   n_b1, n_b2;
    t_ctxd             r54_cd;
    logic [VDIV_W-1:0] r54_b1, r54_b2;
    logic [MSUM_W-1:0] r54_msum;

    assign n_avan = r53_van[VAN_W] ? VAN_W'(-r53_van) : VAN_W'(r53_van);
    assign n_b1   = VP_W'(n_avan * r53_m2);
    assign n_b2   = VP_W'(n_avan * r53_m1);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r54_cd.c    <= r53_cc;
            r54_cd.vneg <= r53_van[VAN_W];
            r54_cd.imp  <= r53_cc.ov && (r53_van[VAN_W] || r53_van == '0);
            r54_b1      <= n_b1[15 +: VDIV_W];
            r54_b2      <= n_b2[15 +: VDIV_W];
            r54_msum    <= r53_msum;
        end
    end

    // Position shares.
    logic [PDIV_W-1:0]     qx1, qy1, qx2, qy2;
    logic [4*PDIV_W-1:0]   pq_d;

    rdpc_div #(.NUM_W(PDIV_W), .DEN_W(RS_W)) u_div_x1 (
        .i_clk (i_clk), .i_en (en), .i_num (r53_ax1), .i_den (r53_cc.rs), .o_quo (qx1)
    );
    rdpc_div #(.NUM_W(PDIV_W), .DEN_W(RS_W)) u_div_y1 (
        .i_clk (i_clk), .i_en (en), .i_num (r53_ay1), .i_den (r53_cc.rs), .o_quo (qy1)
    );
    rdpc_div #(.NUM_W(PDIV_W), .DEN_W(RS_W)) u_div_x2 (
        .i_clk (i_clk), .i_en (en), .i_num (r53_ax2), .i_den (r53_cc.rs), .o_quo (qx2)
    );
    rdpc_div #(.NUM_W(PDIV_W), .DEN_W(RS_W)) u_div_y2 (
        .i_clk (i_clk), .i_en (en), .i_num (r53_ay2), .i_den (r53_cc.rs), .o_quo (qy2)
    );
    rdpc_delay #(.W(4*PDIV_W), .DEPTH(PALIGN)) u_dly_p (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data ({qy2, qx2, qy1, qx1}),
        .o_data (pq_d)
    );

    // Impulse magnitudes.
    logic [VDIV_W-1:0] qg1, qg2;
    logic [$bits(t_ctxd)-1:0] cd_d_bits;
    t_ctxd             cd_d;

    rdpc_div #(.NUM_W(VDIV_W), .DEN_W(MSUM_W)) u_div_g1 (
        .i_clk (i_clk), .i_en (en), .i_num (r54_b1), .i_den (r54_msum), .o_quo (qg1)
    );
    rdpc_div #(.NUM_W(VDIV_W), .DEN_W(MSUM_W)) u_div_g2 (
        .i_clk (i_clk), .i_en (en), .i_num (r54_b2), .i_den (r54_msum), .o_quo (qg2)
    );
    rdpc_delay #(.W($bits(t_ctxd)), .DEPTH(VDIV_W)) u_dly_d (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data (r54_cd),
        .o_data (cd_d_bits)
    );
    assign cd_d = t_ctxd'(cd_d_bits);

    // Stage 88: corrected positions and velocity products.
    localparam int GP_W = GMAG_W + NRM_W;

    logic signed [POS_W+2:0] n_tx1, n_ty1, n_tx2, n_ty2;
    t_ctxd                   r88_cd;
    logic signed [POS_W-1:0] r88_x1, r88_y1, r88_x2, r88_y2;
    logic [GP_W-1:0]         r88_p1x, r88_p1y, r88_p2x, r88_p2y;

    assign n_tx1 = $signed((POS_W+3)'({2'b00, pq_d[0*PDIV_W +: PDIV_W]}));
    assign n_ty1 = $signed((POS_W+3)'({2'b00, pq_d[1*PDIV_W +: PDIV_W]}));
    assign n_tx2 = $signed((POS_W+3)'({2'b00, pq_d[2*PDIV_W +: PDIV_W]}));
    assign n_ty2 = $signed((POS_W+3)'({2'b00, pq_d[3*PDIV_W +: PDIV_W]}));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r88_cd  <= cd_d;
            r88_x1  <= sat_pos((POS_W+3)'(cd_d.c.pair.x1) + (cd_d.c.nxs ? -n_tx1 : n_tx1));
            r88_y1  <= sat_pos((POS_W+3)'(cd_d.c.pair.y1) + (cd_d.c.nys ? -n_ty1 : n_ty1));
            r88_x2  <= sat_pos((POS_W+3)'(cd_d.c.pair.x2) + (cd_d.c.nxs ? n_tx2 : -n_tx2));
            r88_y2  <= sat_pos((POS_W+3)'(cd_d.c.pair.y2) + (cd_d.c.nys ? n_ty2 : -n_ty2));
            r88_p1x <= GP_W'(qg1[GMAG_W-1:0] * cd_d.c.nxm);
            r88_p1y <= GP_W'(qg1[GMAG_W-1:0] * cd_d.c.nym);
            r88_p2x <= GP_W'(qg2[GMAG_W-1:0] * cd_d.c.nxm);
            r88_p2y <= GP_W'(qg2[GMAG_W-1:0] * cd_d.c.nym);
        end
    end

    // Stage 89: output register.
    logic signed [VEL_W+4:0] n_w1x, n_w1y, n_w2x, n_w2y;
    logic                    n_g1neg, n_g2neg;
    logic signed [POS_W-1:0] r_ox1, r_oy1, r_ox2, r_oy2;
    logic signed [VEL_W-1:0] r_ovx1, r_ovy1, r_ovx2, r_ovy2;
    logic                    r_oov, r_oimp;

    assign n_g1neg = !r88_cd.vneg;
    assign n_g2neg = r88_cd.vneg;
    assign n_w1x = $signed((VEL_W+5)'({2'b00, r88_p1x[GP_W-1:16]}));
    assign n_w1y = $signed((VEL_W+5)'({2'b00, r88_p1y[GP_W-1:16]}));
    assign n_w2x = $signed((VEL_W+5)'({2'b00, r88_p2x[GP_W-1:16]}));
    assign n_w2y = $signed((VEL_W+5)'({2'b00, r88_p2y[GP_W-1:16]}));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oov  <= r88_cd.c.ov;
            r_oimp <= r88_cd.imp;
            r_ox1  <= r88_cd.c.ov ? r88_x1 : r88_cd.c.pair.x1;
            r_oy1  <= r88_cd.c.ov ? r88_y1 : r88_cd.c.pair.y1;
            r_ox2  <= r88_cd.c.ov ? r88_x2 : r88_cd.c.pair.x2;
            r_oy2  <= r88_cd.c.ov ? r88_y2 : r88_cd.c.pair.y2;
            if (r88_cd.imp) begin
                r_ovx1 <= sat_vel((VEL_W+5)'(r88_cd.c.pair.vx1)
                                  + ((n_g1neg ^ r88_cd.c.nxs) ? -n_w1x : n_w1x));
                r_ovy1 <= sat_vel((VEL_W+5)'(r88_cd.c.pair.vy1)
                                  + ((n_g1neg ^ r88_cd.c.nys) ? -n_w1y : n_w1y));
                r_ovx2 <= sat_vel((VEL_W+5)'(r88_cd.c.pair.vx2)
                                  + ((n_g2neg ^ r88_cd.c.nxs) ? -n_w2x : n_w2x));
                r_ovy2 <= sat_vel((VEL_W+5)'(r88_cd.c.pair.vy2)
                                  + ((n_g2neg ^ r88_cd.c.nys) ? -n_w2y : n_w2y));
            end else begin
                r_ovx1 <= r88_cd.c.pair.vx1;
                r_ovy1 <= r88_cd.c.pair.vy1;
                r_ovx2 <= r88_cd.c.pair.vx2;
                r_ovy2 <= r88_cd.c.pair.vy2;
            end
        end
    end

    assign o_m_tdata = {4'b0000, r_ovy2, r_ovx2, r_oy2, r_ox2, r_ovy1, r_ovx1, r_oy1, r_ox1};
    assign o_m_tuser = {r_oimp, r_oov};

    a_imp_needs_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[1] && !o_m_tuser[0]))
        else $error("impulse flagged without overlap");

    a_overlap_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[18] && r19_cb.ca.ov) |-> (r19_cb.ovl != '0 && r19_dist < {r19_cb.ca.rs, 8'b0}))
        else $error("overlap depth not positive for an overlapping pair");

    a_normal_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[50] && r51_cc.ov) |-> (r51_cc.nxm <= NRM_W'(ONE_Q16) && r51_cc.nym <= NRM_W'(ONE_Q16)))
        else $error("normal component exceeds one");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import rdpc_pkg::*;

    typedef struct {
        logic signed [POS_W-1:0] x1, y1, x2, y2;
        logic signed [VEL_W-1:0] vx1, vy1, vx2, vy2;
        logic [RAD_W-1:0]        r1, r2;
    } t_disk_pair;

    typedef struct {
        logic [OUT_TDATA_W-1:0] data;
        logic [OUT_TUSER_W-1:0] flags;
    } t_pair_outcome;

    localparam logic signed [POS_W-1:0] P_HI = POS_W'(POS_MAX);
    localparam logic signed [POS_W-1:0] P_LO = POS_W'(POS_MIN);
    localparam logic signed [VEL_W-1:0] V_HI = VEL_W'(VEL_MAX);
    localparam logic signed [VEL_W-1:0] V_LO = VEL_W'(VEL_MIN);

    int mismatch_count = 0;

    task automatic report_mismatch(input string what, input logic [159:0] got,
                                   input logic [159:0] want);
        mismatch_count++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint floor_sqrt(input longint n);
        longint res, bitv;
        res = 0;
        bitv = longint'(1) <<< 62;
        while (bitv > n) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - res - bitv;
                res = (res >>> 1) + bitv;
            end else begin
                res = res >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    function automatic t_pair_outcome resolve_pair(input t_disk_pair p);
        longint x1, y1, x2, y2, vx1, vy1, vx2, vy2, r1, r2;
        longint dx, dy, d2, rs, s, root_d, nx, ny, ovl, den, van, m1, m2, mden, g1, g2;
        logic ov, imp;
        t_pair_outcome o;
        x1 = p.x1; y1 = p.y1; x2 = p.x2; y2 = p.y2;
        vx1 = p.vx1; vy1 = p.vy1; vx2 = p.vx2; vy2 = p.vy2;
        r1 = p.r1; r2 = p.r2;
        ov = 0; imp = 0;
        dx = x1 - x2; dy = y1 - y2;
        d2 = dx * dx + dy * dy;
        rs = r1 + r2;
        s = rs * 256;
        if (d2 < s * s) begin
            ov = 1;
            root_d = floor_sqrt(d2);
            if (root_d > 0) begin
                nx = (dx * ONE_Q16) / root_d;
                ny = (dy * ONE_Q16) / root_d;
            end else begin
                nx = ONE_Q16;
                ny = 0;
            end
            ovl = s - root_d;
            den = rs * ONE_Q16;
            x1 = clamp(x1 + (nx * ovl * r2) / den, POS_W);
            y1 = clamp(y1 + (ny * ovl * r2) / den, POS_W);
            x2 = clamp(x2 - (nx * ovl * r1) / den, POS_W);
            y2 = clamp(y2 - (ny * ovl * r1) / den, POS_W);
            van = (vx1 - vx2) * nx + (vy1 - vy2) * ny;
            if (van <= 0) begin
                imp = 1;
                m1 = r1 * r1;
                m2 = r2 * r2;
                mden = (m1 + m2) * ONE_Q16;
                g1 = (-2 * van * m2) / mden;
                g2 = (2 * van * m1) / mden;
                vx1 = clamp(vx1 + (g1 * nx) / ONE_Q16, VEL_W);
                vy1 = clamp(vy1 + (g1 * ny) / ONE_Q16, VEL_W);
                vx2 = clamp(vx2 + (g2 * nx) / ONE_Q16, VEL_W);
                vy2 = clamp(vy2 + (g2 * ny) / ONE_Q16, VEL_W);
            end
        end
        o.data = {4'b0000, VEL_W'(vy2), VEL_W'(vx2), POS_W'(y2), POS_W'(x2),
                  VEL_W'(vy1), VEL_W'(vx1), POS_W'(y1), POS_W'(x1)};
        o.flags = {imp, ov};
        return o;
    endfunction

    class collision_scoreboard;
        t_pair_outcome pending[$];

        function void note_pair(input t_disk_pair p);
            pending.push_back(resolve_pair(p));
        endfunction

        task check_outcome(input logic [OUT_TDATA_W-1:0] data,
                           input logic [OUT_TUSER_W-1:0] flags);
            t_pair_outcome e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected item", 160'(data), '0);
                return;
            end
            e = pending.pop_front();
            if (data[19:0] !== e.data[19:0])
                report_mismatch("new_first_x", 160'(data[19:0]), 160'(e.data[19:0]));
            if (data[39:20] !== e.data[39:20])
                report_mismatch("new_first_y", 160'(data[39:20]), 160'(e.data[39:20]));
            if (data[58:40] !== e.data[58:40])
                report_mismatch("new_first_vx", 160'(data[58:40]), 160'(e.data[58:40]));
            if (data[77:59] !== e.data[77:59])
                report_mismatch("new_first_vy", 160'(data[77:59]), 160'(e.data[77:59]));
            if (data[97:78] !== e.data[97:78])
                report_mismatch("new_second_x", 160'(data[97:78]), 160'(e.data[97:78]));
            if (data[117:98] !== e.data[117:98])
                report_mismatch("new_second_y", 160'(data[117:98]), 160'(e.data[117:98]));
            if (data[136:118] !== e.data[136:118])
                report_mismatch("new_second_vx", 160'(data[136:118]),
                                160'(e.data[136:118]));
            if (data[155:137] !== e.data[155:137])
                report_mismatch("new_second_vy", 160'(data[155:137]),
                                160'(e.data[155:137]));
            if (data[159:156] !== 4'b0)
                report_mismatch("zero fill", 160'(data[159:156]), '0);
            if (flags[0] !== e.flags[0])
                report_mismatch("overlapped", 160'(flags[0]), 160'(e.flags[0]));
            if (flags[1] !== e.flags[1])
                report_mismatch("impulse_applied", 160'(flags[1]), 160'(e.flags[1]));
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_s_tvalid = 0;
    logic [IN_TDATA_W-1:0] i_s_tdata = '0;
    logic i_m_tready = 0;
    logic o_s_tready, o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [OUT_TUSER_W-1:0] o_m_tuser;

    collision_scoreboard board = new();
    bit hold_off = 0;
    bit steady = 0;
    int quiet_cycles = 0;
    t_disk_pair offered;

    resolve_disk_pair_collision dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic logic [IN_TDATA_W-1:0] pack_pair(input t_disk_pair p);
        return {p.vy2, p.vx2, p.r2, p.y2, p.x2, p.vy1, p.vx1, p.r1, p.y1, p.x1};
    endfunction

    task automatic offer_pair(input t_disk_pair p);
        while (!steady && $urandom_range(99) < 33) begin
            i_s_tvalid <= 0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata <= pack_pair(p);
        offered = p;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) board.note_pair(offered);
            if (o_m_tvalid && i_m_tready) board.check_outcome(o_m_tdata, o_m_tuser);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles > 5000) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 0;
        end else begin
            i_m_tready <= !hold_off && (steady || $urandom_range(99) >= 33);
        end
    end

    function automatic t_disk_pair random_pair(input bit near);
        t_disk_pair p;
        p.r1 = RAD_W'($urandom_range(63, 1));
        p.r2 = RAD_W'($urandom_range(63, 1));
        p.x1 = POS_W'($urandom); p.y1 = POS_W'($urandom);
        p.vx1 = VEL_W'($urandom); p.vy1 = VEL_W'($urandom);
        p.vx2 = VEL_W'($urandom); p.vy2 = VEL_W'($urandom);
        if (near) begin
            p.x2 = p.x1 + POS_W'($urandom_range(65535)) - POS_W'(32768);
            p.y2 = p.y1 + POS_W'($urandom_range(65535)) - POS_W'(32768);
        end else begin
            p.x2 = POS_W'($urandom); p.y2 = POS_W'($urandom);
        end
        return p;
    endfunction

    initial begin
        t_disk_pair p;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        p = '{x1: 0, y1: 0, x2: 0, y2: 0, vx1: 0, vy1: 0, vx2: 0, vy2: 0, r1: 1, r2: 1};
        offer_pair(p);
        p.vx1 = 1000; offer_pair(p);
        p.r1 = 63; p.r2 = 63; p.x1 = P_HI; p.x2 = P_HI; p.vx1 = V_LO;
        p.vx2 = V_HI; offer_pair(p);
        p.x1 = P_LO; p.x2 = P_LO; p.y1 = P_HI; p.y2 = P_HI - POS_W'(100);
        p.vy1 = V_HI; p.vy2 = V_LO; offer_pair(p);
        p.x2 = P_LO + POS_W'(300); p.y2 = P_HI; p.vx1 = V_HI; p.vx2 = V_LO;
        offer_pair(p);
        p = '{x1: 0, y1: 0, x2: 512, y2: 0, vx1: 256, vy1: 0, vx2: -256, vy2: 0,
              r1: 1, r2: 1};
        offer_pair(p);
        p.vx1 = -256; p.vx2 = 256; offer_pair(p);
        p.vx1 = 0; p.vx2 = 0; p.vy1 = 500; p.vy2 = 500; p.x2 = 300; offer_pair(p);
        p.x2 = P_HI; p.x1 = P_LO; offer_pair(p);
        p = '{x1: P_HI, y1: P_LO, x2: P_LO, y2: P_HI, vx1: V_HI,
              vy1: V_LO, vx2: V_LO, vy2: V_HI, r1: 63, r2: 1};
        offer_pair(p);
        p = '{x1: 100, y1: -100, x2: 90, y2: -90, vx1: V_LO, vy1: V_HI,
              vx2: V_HI, vy2: V_LO, r1: 1, r2: 63};
        offer_pair(p);

        fork
            begin
                @(negedge i_clk);
                hold_off = 1;
                repeat (300) @(negedge i_clk);
                hold_off = 0;
            end
            begin
                steady = 1;
                repeat (200) offer_pair(random_pair(1));
                steady = 0;
            end
        join

        repeat (600) offer_pair(random_pair($urandom_range(99) < 75));
        i_s_tvalid <= 0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

FILE: sim.f
design/rdpc_pkg.sv
design/rdpc_delay.sv
design/rdpc_sqrt.sv
design/rdpc_div.sv
design/resolve_disk_pair_collision.sv
tb/sv/tb.sv
